[sv/sep_pkg.sv]
// Shared types and constants for the excitation and phase block.
package sep_pkg;

    localparam int MASK_W = 64;
    localparam int IDX_W  = 6;
    localparam int RANK_W = 7;
    localparam int DEG_W  = 8;
    localparam int SIGN_W = 2;

    localparam logic [SIGN_W-1:0] SIGN_PLUS  = 2'd0;
    localparam logic [SIGN_W-1:0] SIGN_MINUS = 2'd1;
    localparam logic [SIGN_W-1:0] SIGN_ZERO  = 2'd2;

    typedef struct packed {
        logic [MASK_W-1:0] bra_alpha;
        logic [MASK_W-1:0] bra_beta;
        logic [MASK_W-1:0] ket_alpha;
        logic [MASK_W-1:0] ket_beta;
    } t_sep_in;

    typedef struct packed {
        logic [RANK_W-1:0] alpha_rank;
        logic [RANK_W-1:0] beta_rank;
        logic [DEG_W-1:0]  total_degree;
        logic [IDX_W-1:0]  alpha_hole_first;
        logic [IDX_W-1:0]  alpha_hole_second;
        logic [IDX_W-1:0]  alpha_particle_first;
        logic [IDX_W-1:0]  alpha_particle_second;
        logic [IDX_W-1:0]  beta_hole_first;
        logic [IDX_W-1:0]  beta_hole_second;
        logic [IDX_W-1:0]  beta_particle_first;
        logic [IDX_W-1:0]  beta_particle_second;
        logic [SIGN_W-1:0] sign_code;
    } t_sep_out;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [IDX_W-1:0]  hole0;
        logic [IDX_W-1:0]  hole1;
        logic [IDX_W-1:0]  part0;
        logic [IDX_W-1:0]  part1;
        logic              parity;
    } t_sep_lane_res;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_sep_ctl;

endpackage

[sv/sep_lane.sv]
// One spin lane: hole/particle masks, counts, indices and phase parity.
module sep_lane import sep_pkg::*; #(
    parameter int ORBITAL_BITS = 64,
    parameter int MAX_DEGREE   = 2
) (
    input  logic              i_clk,
    input  t_sep_ctl          i_ctl,
    input  logic [MASK_W-1:0] i_bra,
    input  logic [MASK_W-1:0] i_ket,
    output t_sep_lane_res     o_res
);

    localparam int OB = ORBITAL_BITS;
    localparam int CW = $clog2(ORBITAL_BITS + 1);

    // stage 1
    logic [OB-1:0] r_hm, r_pm, r_bra1;
    logic [CW-1:0] r_nh, r_np;
    logic [OB-1:0] n_hm, n_pm;
    logic [CW-1:0] n_nh, n_np;

    always_comb begin
        n_hm = i_ket[OB-1:0] & ~i_bra[OB-1:0];
        n_pm = i_bra[OB-1:0] & ~i_ket[OB-1:0];
        n_nh = '0;
        n_np = '0;
        for (int i = 0; i < OB; i++) begin
            n_nh = n_nh + CW'(n_hm[i]);
            n_np = n_np + CW'(n_pm[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_hm   <= n_hm;
            r_pm   <= n_pm;
            r_bra1 <= i_bra[OB-1:0];
            r_nh   <= n_nh;
            r_np   <= n_np;
        end
    end

    // stage 2
    logic [OB-1:0]     r_bra2;
    logic              r_two;
    logic [RANK_W-1:0] r_rank;
    logic [IDX_W-1:0]  r_h0, r_h1, r_p0, r_p1;

    logic [OB-1:0]    h_lo, h_rest, h_lo2, p_lo, p_rest, p_lo2;
    logic [IDX_W-1:0] h0_idx, h1_idx, p0_idx, p1_idx;
    logic             in_range, use0, use1;
    logic [RANK_W-1:0] n_rank;

    always_comb begin
        h_lo   = r_hm & (~r_hm + 1'b1);
        h_rest = r_hm & ~h_lo;
        h_lo2  = h_rest & (~h_rest + 1'b1);
        p_lo   = r_pm & (~r_pm + 1'b1);
        p_rest = r_pm & ~p_lo;
        p_lo2  = p_rest & (~p_rest + 1'b1);
        h0_idx = '0;
        h1_idx = '0;
        p0_idx = '0;
        p1_idx = '0;
        for (int i = 0; i < OB; i++) begin
            if (h_lo[i])  h0_idx = h0_idx | IDX_W'(i);
            if (h_lo2[i]) h1_idx = h1_idx | IDX_W'(i);
            if (p_lo[i])  p0_idx = p0_idx | IDX_W'(i);
            if (p_lo2[i]) p1_idx = p1_idx | IDX_W'(i);
        end
        in_range = (r_nh == r_np) && (r_nh <= CW'(2));
        use0     = in_range && (r_nh != '0);
        use1     = in_range && (r_nh == CW'(2));
        n_rank   = (r_nh == r_np) ? RANK_W'(r_nh) : RANK_W'(MAX_DEGREE + 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_bra2 <= r_bra1;
            r_two  <= use1;
            r_rank <= n_rank;
            r_h0   <= use0 ? h0_idx : '0;
            r_p0   <= use0 ? p0_idx : '0;
            r_h1   <= use1 ? h1_idx : '0;
            r_p1   <= use1 ? p1_idx : '0;
        end
    end

    // stage 3: occupied bra orbitals strictly inside each interval, plus crossing
    logic [IDX_W-1:0] a, b, c, e;
    logic [OB-1:0]    between;
    logic             crossed;
    t_sep_lane_res    n_res;

    always_comb begin
        a = (r_h0 < r_p0) ? r_h0 : r_p0;
        b = (r_h0 < r_p0) ? r_p0 : r_h0;
        c = (r_h1 < r_p1) ? r_h1 : r_p1;
        e = (r_h1 < r_p1) ? r_p1 : r_h1;
        for (int i = 0; i < OB; i++) begin
            between[i] = ((IDX_W'(i) > a) && (IDX_W'(i) < b))
                       ^ ((IDX_W'(i) > c) && (IDX_W'(i) < e));
        end
        crossed = r_two && (((c > a) && (c < b) && (e > b)) ||
                            ((a > c) && (a < e) && (b > e)));
        n_res.rank   = r_rank;
        n_res.hole0  = r_h0;
        n_res.hole1  = r_h1;
        n_res.part0  = r_p0;
        n_res.part1  = r_p1;
        n_res.parity = (^(r_bra2 & between)) ^ crossed;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            o_res <= n_res;
        end
    end

endmodule

[sv/sep_merge.sv]
// Merge stage: combines the two spin lanes into the output item.
module sep_merge import sep_pkg::*; #(
    parameter int MAX_DEGREE = 2
) (
    input  logic          i_clk,
    input  logic          i_ld,
    input  t_sep_lane_res i_alpha,
    input  t_sep_lane_res i_beta,
    output t_sep_out      o_item
);

    logic [DEG_W-1:0] degree;
    logic             over;
    t_sep_out         n_item;

    always_comb begin
        degree = DEG_W'(i_alpha.rank) + DEG_W'(i_beta.rank);
        over   = degree > DEG_W'(MAX_DEGREE);
        n_item = '0;
        n_item.alpha_rank   = i_alpha.rank;
        n_item.beta_rank    = i_beta.rank;
        n_item.total_degree = degree;
        if (over) begin
            n_item.sign_code = SIGN_ZERO;
        end else begin
            n_item.alpha_hole_first      = i_alpha.hole0;
            n_item.alpha_hole_second     = i_alpha.hole1;
            n_item.alpha_particle_first  = i_alpha.part0;
            n_item.alpha_particle_second = i_alpha.part1;
            n_item.beta_hole_first       = i_beta.hole0;
            n_item.beta_hole_second      = i_beta.hole1;
            n_item.beta_particle_first   = i_beta.part0;
            n_item.beta_particle_second  = i_beta.part1;
            n_item.sign_code = (i_alpha.parity ^ i_beta.parity) ? SIGN_MINUS : SIGN_PLUS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            o_item <= n_item;
        end
    end

endmodule

[sv/slater_excitation_phase_core.sv]
// Top level: two spin lanes, merge stage and pipeline flow control.
//
//  channel | direction | handshake            | payload
//  input   | in        | i_valid / o_stall    | i_item (t_sep_in)
//  output  | out       | o_valid / i_stall    | o_item (t_sep_out)
//
// One item per cycle sustained while i_stall is low; the path is three lane
// stages plus the merge register.
// Each stage advances when it is empty or the next stage advances, so
// bubbles are squeezed out and o_stall rises only when all four stages
// hold items and i_stall is high.
// Reset clears the stage valid bits only.
module slater_excitation_phase_core import sep_pkg::*; #(
    parameter int MAX_DEGREE   = 2,
    parameter int ORBITAL_BITS = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_sep_in  i_item,
    output logic     o_valid,
    input  logic     i_stall,
    output t_sep_out o_item
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic n_v1, n_v2, n_v3, n_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    t_sep_ctl ctl;
    t_sep_lane_res res_alpha, res_beta;

    always_comb begin
        rdy4    = !r_v4 || !i_stall;
        rdy3    = !r_v3 || rdy4;
        rdy2    = !r_v2 || rdy3;
        rdy1    = !r_v1 || rdy2;
        ctl.ld1 = i_valid && rdy1;
        ctl.ld2 = r_v1 && rdy2;
        ctl.ld3 = r_v2 && rdy3;
        n_v1    = rdy1 ? i_valid : r_v1;
        n_v2    = rdy2 ? r_v1 : r_v2;
        n_v3    = rdy3 ? r_v2 : r_v3;
        n_v4    = rdy4 ? r_v3 : r_v4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
            r_v4 <= n_v4;
        end
    end

    assign o_stall = !rdy1;
    assign o_valid = r_v4;

    sep_lane #(
        .ORBITAL_BITS(ORBITAL_BITS),
        .MAX_DEGREE  (MAX_DEGREE)
    ) u_lane_alpha (
        .i_clk(i_clk),
        .i_ctl(ctl),
        .i_bra(i_item.bra_alpha),
        .i_ket(i_item.ket_alpha),
        .o_res(res_alpha)
    );

    sep_lane #(
        .ORBITAL_BITS(ORBITAL_BITS),
        .MAX_DEGREE  (MAX_DEGREE)
    ) u_lane_beta (
        .i_clk(i_clk),
        .i_ctl(ctl),
        .i_bra(i_item.bra_beta),
        .i_ket(i_item.ket_beta),
        .o_res(res_beta)
    );

    sep_merge #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_merge (
        .i_clk  (i_clk),
        .i_ld   (r_v3 && rdy4),
        .i_alpha(res_alpha),
        .i_beta (res_beta),
        .o_item (o_item)
    );

    a_degree_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.total_degree ==
                     DEG_W'(o_item.alpha_rank) + DEG_W'(o_item.beta_rank)))
        else $error("total degree is not the sum of ranks");

    a_zero_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_item.sign_code == SIGN_ZERO) ==
                     (o_item.total_degree > DEG_W'(MAX_DEGREE))))
        else $error("zero phase does not match degree overflow");

    a_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.sign_code == SIGN_ZERO) |->
            (o_item.alpha_hole_first == '0 && o_item.alpha_particle_first == '0 &&
             o_item.beta_hole_first == '0 && o_item.beta_particle_first == '0))
        else $error("indices not cleared above max degree");

    a_hold_stage3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !rdy4) |=> r_v3)
        else $error("item dropped from lane output stage");

    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_v1 && r_v2 && r_v3 && r_v4) |-> !o_stall)
        else $error("stall raised with a free stage");

endmodule

[tb/sv/tb.sv]
// Testbench for the excitation and phase core: scoreboard, stimulus and checks.
import sep_pkg::*;

class excitation_scoreboard;
    localparam int MAX_EXCITATION = 2;

    t_sep_out excitations_due[$];
    int       mismatches;
    int       checked;

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    function int occupied_between(logic [MASK_W-1:0] occ, int p, int q);
        int lo, hi, n;
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
        n  = 0;
        for (int i = lo + 1; i < hi; i++) n += int'(occ[i]);
        return n;
    endfunction

    function void diff_lane(input logic [MASK_W-1:0] bra, ket,
                            output int rank, h0, h1, p0, p1);
        logic [MASK_W-1:0] hm, pm;
        int nh, np, k, m;
        hm = ket & ~bra;
        pm = bra & ~ket;
        nh = $countones(hm);
        np = $countones(pm);
        h0 = 0; h1 = 0; p0 = 0; p1 = 0;
        k  = 0; m  = 0;
        if (nh != np) begin
            rank = MAX_EXCITATION + 1;
        end else begin
            rank = nh;
            if (nh <= 2) begin
                for (int i = 0; i < MASK_W; i++) begin
                    if (hm[i]) begin
                        if (k == 0) h0 = i; else h1 = i;
                        k++;
                    end
                    if (pm[i]) begin
                        if (m == 0) p0 = i; else p1 = i;
                        m++;
                    end
                end
            end
        end
    endfunction

    function int lane_swaps(logic [MASK_W-1:0] occ, int rank, int h0, int h1, int p0, int p1);
        int n, a, b, c, e;
        n = 0;
        if (rank >= 1) n += occupied_between(occ, h0, p0);
        if (rank == 2) begin
            n += occupied_between(occ, h1, p1);
            a = (h0 < p0) ? h0 : p0;
            b = (h0 < p0) ? p0 : h0;
            c = (h1 < p1) ? h1 : p1;
            e = (h1 < p1) ? p1 : h1;
            if ((c > a && c < b && e > b) || (a > c && a < e && b > e)) n++;
        end
        return n;
    endfunction

    function t_sep_out predict_excitation(t_sep_in pair);
        t_sep_out r;
        int ra, ah0, ah1, ap0, ap1;
        int rb, bh0, bh1, bp0, bp1;
        int swaps;
        r = '0;
        diff_lane(pair.bra_alpha, pair.ket_alpha, ra, ah0, ah1, ap0, ap1);
        diff_lane(pair.bra_beta, pair.ket_beta, rb, bh0, bh1, bp0, bp1);
        r.alpha_rank   = RANK_W'(ra);
        r.beta_rank    = RANK_W'(rb);
        r.total_degree = DEG_W'(ra + rb);
        if (ra + rb > MAX_EXCITATION) begin
            r.sign_code = SIGN_ZERO;
        end else begin
            r.alpha_hole_first      = IDX_W'(ah0);
            r.alpha_hole_second     = IDX_W'(ah1);
            r.alpha_particle_first  = IDX_W'(ap0);
            r.alpha_particle_second = IDX_W'(ap1);
            r.beta_hole_first       = IDX_W'(bh0);
            r.beta_hole_second      = IDX_W'(bh1);
            r.beta_particle_first   = IDX_W'(bp0);
            r.beta_particle_second  = IDX_W'(bp1);
            swaps = lane_swaps(pair.bra_alpha, ra, ah0, ah1, ap0, ap1)
                  + lane_swaps(pair.bra_beta, rb, bh0, bh1, bp0, bp1);
            r.sign_code = swaps[0] ? SIGN_MINUS : SIGN_PLUS;
        end
        return r;
    endfunction

    function void note_determinant_pair(t_sep_in pair);
        excitations_due = {excitations_due, predict_excitation(pair)};
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
            flag($sformatf("item %0d %s: expected %0d, got %0d", checked, name, want, got));
    endfunction

    function void check_excitation(t_sep_out got);
        t_sep_out want;
        if (excitations_due.size() == 0) begin
            flag($sformatf("item %0d arrived with nothing expected: %p", checked, got));
        end else begin
            want = excitations_due.pop_front();
            compare_field("alpha_rank", 8'(want.alpha_rank), 8'(got.alpha_rank));
            compare_field("beta_rank", 8'(want.beta_rank), 8'(got.beta_rank));
            compare_field("total_degree", want.total_degree, got.total_degree);
            compare_field("alpha_hole_first", 8'(want.alpha_hole_first),
                          8'(got.alpha_hole_first));
            compare_field("alpha_hole_second", 8'(want.alpha_hole_second),
                          8'(got.alpha_hole_second));
            compare_field("alpha_particle_first", 8'(want.alpha_particle_first),
                          8'(got.alpha_particle_first));
            compare_field("alpha_particle_second", 8'(want.alpha_particle_second),
                          8'(got.alpha_particle_second));
            compare_field("beta_hole_first", 8'(want.beta_hole_first),
                          8'(got.beta_hole_first));
            compare_field("beta_hole_second", 8'(want.beta_hole_second),
                          8'(got.beta_hole_second));
            compare_field("beta_particle_first", 8'(want.beta_particle_first),
                          8'(got.beta_particle_first));
            compare_field("beta_particle_second", 8'(want.beta_particle_second),
                          8'(got.beta_particle_second));
            compare_field("sign_code", 8'(want.sign_code), 8'(got.sign_code));
        end
        checked++;
    endfunction
endclass

module tb;
    localparam int ITEM_COUNT   = 1550;
    localparam int DIRECTED     = 16;
    localparam int RANDOM_COUNT = ITEM_COUNT - DIRECTED;
    localparam int HOLD_CYCLES  = 48;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [MASK_W-1:0] ONES = {MASK_W{1'b1}};
    localparam logic [MASK_W-1:0] ODD  = {(MASK_W/2){2'b10}};
    localparam logic [MASK_W-1:0] EVEN = {(MASK_W/2){2'b01}};

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_sep_in  i_item;
    logic     o_valid;
    logic     i_stall;
    t_sep_out o_item;

    excitation_scoreboard sb = new();

    int sent;
    int quiet_run;
    bit hold_now;
    bit calm;

    slater_excitation_phase_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_sep_in make_item(logic [MASK_W-1:0] ba, bb, ka, kb);
        t_sep_in it;
        it.bra_alpha = ba;
        it.bra_beta  = bb;
        it.ket_alpha = ka;
        it.ket_beta  = kb;
        return it;
    endfunction

    function automatic logic [MASK_W-1:0] random_mask();
        logic [MASK_W-1:0] a, b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return a & b & {$urandom, $urandom};
            1: return a & b;
            2, 3: return a;
            4: return a | b;
            default: begin
                if ($urandom_range(0, 1)) return ONES ^ (64'd1 << $urandom_range(0, 63));
                return 64'd1 << $urandom_range(0, 63);
            end
        endcase
    endfunction

    // move count electrons from occupied bra orbitals to empty ones
    function automatic logic [MASK_W-1:0] excite(logic [MASK_W-1:0] bra, int count);
        logic [MASK_W-1:0] ket;
        int i, j, pos;
        ket = bra;
        for (int k = 0; k < count; k++) begin
            i = -1;
            j = -1;
            for (int t = 0; t < 256 && (i < 0 || j < 0); t++) begin
                pos = $urandom_range(0, MASK_W - 1);
                if (i < 0 && bra[pos] && ket[pos]) i = pos;
                else if (j < 0 && !bra[pos] && !ket[pos]) j = pos;
            end
            if (i >= 0 && j >= 0) begin
                ket[i] = 1'b0;
                ket[j] = 1'b1;
            end
        end
        return ket;
    endfunction

    function automatic t_sep_in random_item();
        t_sep_in it;
        int kind, na, nb;
        kind = $urandom_range(0, 99);
        it.bra_alpha = random_mask();
        it.bra_beta  = random_mask();
        if (kind < 70) begin
            na = $urandom_range(0, 2);
            nb = $urandom_range(0, 2 - na);
        end else if (kind < 85) begin
            na = $urandom_range(0, 4);
            nb = $urandom_range(0, 4);
        end else begin
            na = $urandom_range(0, 2);
            nb = $urandom_range(0, 2);
        end
        it.ket_alpha = excite(it.bra_alpha, na);
        it.ket_beta  = excite(it.bra_beta, nb);
        if (kind >= 95) begin
            it.ket_alpha = random_mask();
            it.ket_beta  = random_mask();
        end else if (kind >= 85) begin
            if ($urandom_range(0, 1)) it.ket_alpha[$urandom_range(0, 63)] ^= 1'b1;
            else it.ket_beta[$urandom_range(0, 63)] ^= 1'b1;
        end
        return it;
    endfunction

    // called and returns at a falling edge
    task automatic send_item(input t_sep_in item);
        if (!calm && !hold_now && (sent % 256) >= 48 && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_item  <= item;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_determinant_pair(item);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic run_directed();
        send_item(make_item('0, '0, '0, '0));
        send_item(make_item(ONES, ONES, ONES, ONES));
        send_item(make_item(ONES, 64'h0F0F, '0, 64'h0F0F));
        send_item(make_item(EVEN, EVEN, ODD, ODD));
        send_item(make_item(64'h8000_0000_0000_00F0, 64'h3, 64'h0000_0000_0000_00F1, 64'h3));
        send_item(make_item(64'h2, '0, 64'h1, '0));
        send_item(make_item('0, 64'h0000_FF00_0000_0001, '0, 64'h8000_FF00_0000_0000));
        send_item(make_item(64'h3C8, 64'hF, 64'h16C, 64'hF));
        send_item(make_item(64'h5, 64'h10_800A, 64'h5, 64'h8403));
        send_item(make_item(~64'h3, ONES, 64'h3FFF_FFFF_FFFF_FFFF, ONES));
        send_item(make_item(64'h10, 64'h8000_0000_0000_0000, 64'h1, 64'h4000_0000_0000_0000));
        send_item(make_item(64'h7, 64'h1, 64'h38, 64'h1));
        send_item(make_item(64'h3, 64'h1, 64'hC, 64'h2));
        send_item(make_item(64'h1, 64'h1, 64'h2, 64'h3));
        send_item(make_item(64'hC, '0, 64'h3, '0));
        send_item(make_item(64'h8000_0000_0000_0000, ONES, 64'h4000_0000_0000_0000, ONES));
    endtask

    task automatic run_random();
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            if (n == 700) hold_now = 1'b1;
            calm = (n >= RANDOM_COUNT - 200);
            send_item(random_item());
        end
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_now) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
                hold_now = 1'b0;
            end else if (!calm && ((sent + 128) % 256) >= 48 && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_excitation(o_item);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_run = 0;
        else quiet_run++;
        if (quiet_run >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_stall   = 1'b0;
        i_item    = '0;
        hold_now  = 1'b0;
        calm      = 1'b0;
        sent      = 0;
        quiet_run = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        i_valid <= 1'b0;
        while (sb.excitations_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.excitations_due.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
